[hdl/sai_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sai_pkg: shared types and constants for the sorted array insert block
// widths of the item fields, default table size, and the command and status
// bundles between the controller and the datapath
// ----------------------------------------------------------------------------
package sai_pkg;

  // field widths
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned FillW = 5;

  // default table size
  localparam int unsigned SaiCapacity = 16;

  // item modes
  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRead   = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the item and issue the first table read
    logic shift;   // move the entry just read up one place
    logic place;   // write the new value into the gap and finish
    logic reject;  // finish an insert into a full table
    logic read;    // finish a read item
  } sai_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;     // table holds its full capacity
    logic empty;    // table holds nothing
    logic greater;  // entry just read is greater than the new value
    logic j_one;    // scan index has reached the second slot
  } sai_sts_t;

endpackage : sai_pkg
`default_nettype wire

[hdl/sorted_array_insert_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_array_insert_top: ascending table of signed 32-bit values
// inserts a value after all equal or smaller entries, or reads one entry
//
//   channel   handshake            payload
//   item in   start_i, busy_o      mode_i, value_i, read_index_i
//   result    done_o (one cycle)   accepted_o, position_o, fill_count_o,
//                                  read_value_o, read_valid_o
//
// an insert moving k entries issues load, k shifts and place; a read or a
// rejected insert issues load, then read or reject; the table's single write
// port moves one entry per cycle; the next item is taken in the cycle the
// result beat shows; reset empties the table at once; entries at or above
// the fill count are never returned; the receiver cannot stall: each result
// beat is valid for exactly one cycle
// ----------------------------------------------------------------------------
module sorted_array_insert_top #(
  parameter int unsigned CAPACITY = sai_pkg::SaiCapacity
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        mode_i,
  input  wire logic signed [sai_pkg::DataW-1:0] value_i,
  input  wire logic [sai_pkg::IdxW-1:0]    read_index_i,
  output logic                             done_o,
  output logic                             accepted_o,
  output logic [sai_pkg::IdxW-1:0]         position_o,
  output logic [sai_pkg::FillW-1:0]        fill_count_o,
  output logic signed [sai_pkg::DataW-1:0] read_value_o,
  output logic                             read_valid_o
);
  import sai_pkg::*;

  sai_cmd_t cmd;
  sai_sts_t sts;

  // sequencer
  sai_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // table and result registers
  sai_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .read_index_i (read_index_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .accepted_o   (accepted_o),
    .position_o   (position_o),
    .fill_count_o (fill_count_o),
    .read_value_o (read_value_o),
    .read_valid_o (read_valid_o)
  );

endmodule : sorted_array_insert_top
`default_nettype wire

[hdl/sai_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sai_datapath: table memory, fill count, scan index and result registers
// moves one entry per cycle while the controller scans down from the top
// ----------------------------------------------------------------------------
module sai_datapath #(
  parameter int unsigned CAPACITY = sai_pkg::SaiCapacity
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        mode_i,
  input  wire logic signed [sai_pkg::DataW-1:0] value_i,
  input  wire logic [sai_pkg::IdxW-1:0]    read_index_i,
  input  wire sai_pkg::sai_cmd_t           cmd_i,
  output sai_pkg::sai_sts_t                sts_o,
  output logic                             done_o,
  output logic                             accepted_o,
  output logic [sai_pkg::IdxW-1:0]         position_o,
  output logic [sai_pkg::FillW-1:0]        fill_count_o,
  output logic signed [sai_pkg::DataW-1:0] read_value_o,
  output logic                             read_valid_o
);
  import sai_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > IdxW) ? CW : IdxW;

  // table storage and its registered read port
  logic signed [DataW-1:0] mem_q [CAPACITY];
  logic signed [DataW-1:0] rdata_q;

  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           j_q, j_d;
  logic signed [DataW-1:0] value_q;
  logic                    in_range_q;

  logic                    rd_en;
  logic [AW-1:0]           raddr;
  logic                    wr_en;
  logic [AW-1:0]           waddr;
  logic signed [DataW-1:0] wdata;

  // status back to the controller
  assign sts_o.full    = (count_q == CW'(CAPACITY));
  assign sts_o.empty   = (count_q == '0);
  assign sts_o.greater = (rdata_q > value_q);
  assign sts_o.j_one   = (j_q == AW'(1));

  // memory port selection and index update
  always_comb begin
    rd_en   = 1'b0;
    raddr   = '0;
    wr_en   = 1'b0;
    waddr   = j_q;
    wdata   = value_q;
    j_d     = j_q;
    count_d = count_q;
    if (cmd_i.load) begin
      rd_en = 1'b1;
      j_d   = AW'(count_q);
      if (mode_i == ModeRead) begin
        raddr = AW'(read_index_i);
      end else begin
        raddr = AW'(count_q - CW'(1));
      end
    end
    if (cmd_i.shift) begin
      wr_en = 1'b1;
      wdata = rdata_q;
      j_d   = j_q - AW'(1);
      rd_en = 1'b1;
      raddr = j_q - AW'(2);
    end
    if (cmd_i.place) begin
      wr_en   = 1'b1;
      wdata   = value_q;
      count_d = count_q + CW'(1);
    end
  end

  // table write and read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // item latches
  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    if (cmd_i.load) begin
      value_q    <= value_i;
      in_range_q <= (XW'(read_index_i) < XW'(count_q));
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.place | cmd_i.reject | cmd_i.read;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      accepted_o   <= 1'b1;
      position_o   <= IdxW'(j_q);
      fill_count_o <= FillW'(count_d);
      read_value_o <= '0;
      read_valid_o <= 1'b0;
    end else if (cmd_i.reject) begin
      accepted_o   <= 1'b0;
      position_o   <= '0;
      fill_count_o <= FillW'(count_q);
      read_value_o <= '0;
      read_valid_o <= 1'b0;
    end else if (cmd_i.read) begin
      accepted_o   <= 1'b0;
      position_o   <= '0;
      fill_count_o <= FillW'(count_q);
      read_value_o <= in_range_q ? rdata_q : '0;
      read_valid_o <= in_range_q;
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  // a placed value grows the table by one and gives a beat
  a_place_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |=> (done_o && (count_q == $past(count_q) + CW'(1))))
    else $error("place did not grow the table");

  // a beat never claims both a stored insert and a valid read
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(accepted_o && read_valid_o))
    else $error("result marks insert and read together");
`endif

endmodule : sai_datapath
`default_nettype wire

[hdl/sai_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sai_ctrl: sequencer for the sorted array insert block
// takes an item, scans the table downward one entry per cycle, then finishes
// ----------------------------------------------------------------------------
module sai_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              mode_i,
  input  wire sai_pkg::sai_sts_t sts_i,
  output sai_pkg::sai_cmd_t      cmd_o,
  output logic                   busy_o
);
  import sai_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPlace,
    StReject,
    StRead
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (mode_i == ModeRead) begin
            state_d = StRead;
          end else if (sts_i.full) begin
            state_d = StReject;
          end else if (sts_i.empty) begin
            state_d = StPlace;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          if (sts_i.j_one) begin
            state_d = StPlace;
          end
        end else begin
          cmd_o.place = 1'b1;
          state_d     = StIdle;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        state_d     = StIdle;
      end
      StReject: begin
        cmd_o.reject = 1'b1;
        state_d      = StIdle;
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_o  <= (state_d != StIdle);
    end
  end

`ifndef NO_ASSERTIONS
  // at most one command in any cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one command at once");

  // every finishing command frees the block for the next item
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.place || cmd_o.reject || cmd_o.read) |=> !busy_o)
    else $error("block still busy after finish");

  // an item is only taken while the block is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o)
    else $error("item taken while busy");
`endif

endmodule : sai_ctrl
`default_nettype wire
